// ===== rtl/pdrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdrs_pkg
// Types and constants shared by the divider ramp sequencer files.
// ----------------------------------------------------------------------------
package pdrs_pkg;

  localparam int unsigned PD_SLOTS = 4;
  localparam int unsigned PD_IDX_W = 2;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic REG_CTL1 = 1'b0;
  localparam logic REG_CTL5 = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic [31:0]                  cur_ctl1;
    logic [31:0]                  cur_ctl5;
    logic [15:0]                  tgt_fbdiv;
    logic [PD_SLOTS-1:0][7:0]     tgt_postdiv;
  } pdrs_req_t;

  typedef struct packed {
    logic        write_valid;
    logic        write_reg;
    logic [31:0] write_data;
    logic        done_res;
  } pdrs_res_t;

  typedef struct packed {
    logic [15:0]              fbdiv_now;
    logic [15:0]              ctl1_low_half;
    logic [PD_SLOTS-1:0][7:0] postdiv_now;
    logic [15:0]              fbdiv_goal;
    logic [PD_SLOTS-1:0][7:0] postdiv_goal;
  } pdrs_state_t;

endpackage
`default_nettype wire

// ===== rtl/pdrs_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdrs_if
// Valid/ready channels for load/tick beats and for write result beats.
// ----------------------------------------------------------------------------
interface pdrs_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] cur_ctl1;
  logic [31:0] cur_ctl5;
  logic [15:0] tgt_fbdiv;
  logic [7:0]  tgt_postdiv0;
  logic [7:0]  tgt_postdiv1;
  logic [7:0]  tgt_postdiv2;
  logic [7:0]  tgt_postdiv3;

  modport source (
    output valid, cmd, cur_ctl1, cur_ctl5, tgt_fbdiv,
           tgt_postdiv0, tgt_postdiv1, tgt_postdiv2, tgt_postdiv3,
    input  ready
  );
  modport sink (
    input  valid, cmd, cur_ctl1, cur_ctl5, tgt_fbdiv,
           tgt_postdiv0, tgt_postdiv1, tgt_postdiv2, tgt_postdiv3,
    output ready
  );
endinterface

interface pdrs_res_if;
  logic        valid;
  logic        ready;
  logic        write_valid;
  logic        write_reg;
  logic [31:0] write_data;
  logic        done_res;

  modport source (
    output valid, write_valid, write_reg, write_data, done_res,
    input  ready
  );
  modport sink (
    input  valid, write_valid, write_reg, write_data, done_res,
    output ready
  );
endinterface
`default_nettype wire

// ===== rtl/pll_divider_ramp_sequencer_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pll_divider_ramp_sequencer_top
// Steps PLL feedback and post dividers toward a target, at most one write per tick.
//
// req_i carries load beats (cmd 0: present control words 1 and 5 and the
// targets) and tick beats (cmd 1). Every request beat yields exactly one
// result beat on res_o: a control word write (write_valid, write_reg,
// write_data) or no write, plus done_res once all dividers match.
// A beat lands in the input register, then the step logic updates the
// ramp state and fills the result register. One beat per cycle is taken
// while res_o is not stalled; the state register feeds back through the
// combinational step logic, so consecutive ticks see each other's effects.
// When res_o is stalled and the result register is full, the input
// register holds and req_i.ready drops once it is full too.
// Reset clears the ramp state to zero and empties both registers; a tick
// before any load reports done with no write.
// ----------------------------------------------------------------------------
module pll_divider_ramp_sequencer_top
  import pdrs_pkg::*;
#(
  parameter int unsigned NUM_POSTDIV = 4
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  pdrs_req_if.sink          req_i,
  pdrs_res_if.source        res_o
);

  localparam int unsigned PdUsed = (NUM_POSTDIV < PD_SLOTS) ? NUM_POSTDIV : PD_SLOTS;

  logic        in_valid_q;
  pdrs_req_t   in_q;
  logic        out_valid_q;
  pdrs_res_t   out_q;
  pdrs_state_t state_q;
  pdrs_state_t state_d;
  pdrs_res_t   res_d;
  logic        advance;
  logic        take;

  assign advance     = in_valid_q & (~out_valid_q | res_o.ready);
  assign req_i.ready = ~in_valid_q | advance;
  assign take        = req_i.valid & req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.cmd            <= req_i.cmd;
      in_q.cur_ctl1       <= req_i.cur_ctl1;
      in_q.cur_ctl5       <= req_i.cur_ctl5;
      in_q.tgt_fbdiv      <= req_i.tgt_fbdiv;
      in_q.tgt_postdiv[0] <= req_i.tgt_postdiv0;
      in_q.tgt_postdiv[1] <= req_i.tgt_postdiv1;
      in_q.tgt_postdiv[2] <= req_i.tgt_postdiv2;
      in_q.tgt_postdiv[3] <= req_i.tgt_postdiv3;
    end
  end

  pdrs_step #(
    .PD_USED (PdUsed)
  ) u_step (
    .req_i   (in_q),
    .state_i (state_q),
    .state_o (state_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.write_valid = out_q.write_valid;
  assign res_o.write_reg   = out_q.write_reg;
  assign res_o.write_data  = out_q.write_data;
  assign res_o.done_res    = out_q.done_res;

endmodule
`default_nettype wire

// ===== rtl/pdrs_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pdrs_step
// One load or tick: next ramp state and the control word write it causes.
// ----------------------------------------------------------------------------
module pdrs_step
  import pdrs_pkg::*;
#(
  parameter int unsigned PD_USED = 4
) (
  input  pdrs_req_t   req_i,
  input  pdrs_state_t state_i,
  output pdrs_state_t state_o,
  output pdrs_res_t   res_o
);

  logic                up_found;
  logic [PD_IDX_W-1:0] up_idx;
  logic                dn_found;
  logic [PD_IDX_W-1:0] dn_idx;
  logic                fb_match;
  logic                pd_match;
  pdrs_state_t         nxt;

  always_comb begin
    up_found = 1'b0;
    up_idx   = '0;
    dn_found = 1'b0;
    dn_idx   = '0;
    for (int k = 0; k < PD_USED; k++) begin
      if (!up_found && (state_i.postdiv_now[k] < state_i.postdiv_goal[k])) begin
        up_found = 1'b1;
        up_idx   = PD_IDX_W'(k);
      end
      if (!dn_found && (state_i.postdiv_now[k] > state_i.postdiv_goal[k])) begin
        dn_found = 1'b1;
        dn_idx   = PD_IDX_W'(k);
      end
    end
  end

  always_comb begin
    nxt               = state_i;
    res_o.write_valid = 1'b0;
    res_o.write_reg   = REG_CTL1;
    res_o.write_data  = '0;
    if (req_i.cmd == CMD_LOAD) begin
      nxt.fbdiv_now     = req_i.cur_ctl1[31:16];
      nxt.ctl1_low_half = req_i.cur_ctl1[15:0];
      nxt.postdiv_now   = req_i.cur_ctl5;
      nxt.fbdiv_goal    = req_i.tgt_fbdiv;
      nxt.postdiv_goal  = req_i.tgt_postdiv;
    end else begin
      priority if (up_found) begin
        nxt.postdiv_now[up_idx] = state_i.postdiv_now[up_idx] + 8'd1;
        res_o.write_valid = 1'b1;
        res_o.write_reg   = REG_CTL5;
        res_o.write_data  = nxt.postdiv_now;
      end else if (state_i.fbdiv_now != state_i.fbdiv_goal) begin
        if (state_i.fbdiv_now < state_i.fbdiv_goal) begin
          nxt.fbdiv_now = state_i.fbdiv_now + 16'd1;
        end else begin
          nxt.fbdiv_now = state_i.fbdiv_now - 16'd1;
        end
        res_o.write_valid = 1'b1;
        res_o.write_reg   = REG_CTL1;
        res_o.write_data  = {nxt.fbdiv_now, state_i.ctl1_low_half};
      end else if (dn_found) begin
        nxt.postdiv_now[dn_idx] = state_i.postdiv_now[dn_idx] - 8'd1;
        res_o.write_valid = 1'b1;
        res_o.write_reg   = REG_CTL5;
        res_o.write_data  = nxt.postdiv_now;
      end else begin
        res_o.write_valid = 1'b0;
      end
    end
    fb_match = (nxt.fbdiv_now == nxt.fbdiv_goal);
    pd_match = 1'b1;
    for (int k = 0; k < PD_USED; k++) begin
      if (nxt.postdiv_now[k] != nxt.postdiv_goal[k]) begin
        pd_match = 1'b0;
      end
    end
    res_o.done_res = fb_match & pd_match;
  end

  assign state_o = nxt;

endmodule
`default_nettype wire

// ===== tb/sv/pdrs_ramp_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pdrs_ramp_checker
// Watches the request and result channels of the divider ramp sequencer.
// Every accepted request beat is run through a local model of the ramp state,
// and the predicted write is queued. Every accepted result beat is compared
// field by field with the oldest queued write. The error count, the number
// of writes still awaited and the number of results checked go to the top.
// ----------------------------------------------------------------------------
module pdrs_ramp_checker
  import pdrs_pkg::*;
#(
  parameter int unsigned NUM_POSTDIV = 4
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  pdrs_req_if  req_i,
  pdrs_res_if  res_i,
  output int   errors_o,
  output int   pending_o,
  output int   checked_o
);

  localparam int PD_USED = (NUM_POSTDIV < PD_SLOTS) ? NUM_POSTDIV : PD_SLOTS;
  localparam int MAX_REPORTS = 10;

  logic [15:0] fb_now;
  logic [15:0] fb_goal;
  logic [15:0] ctl1_lo;
  logic [7:0]  pd_now  [PD_SLOTS];
  logic [7:0]  pd_goal [PD_SLOTS];

  pdrs_res_t   write_q [$];
  pdrs_req_t   seen_beat;
  pdrs_res_t   got;
  pdrs_res_t   want;

  function automatic pdrs_res_t ramp_step(input pdrs_req_t b);
    pdrs_res_t r;
    int        pick;
    bit        settled;
    r    = '0;
    pick = -1;
    if (b.cmd == CMD_LOAD) begin
      fb_now  = b.cur_ctl1[31:16];
      ctl1_lo = b.cur_ctl1[15:0];
      fb_goal = b.tgt_fbdiv;
      for (int k = 0; k < PD_SLOTS; k++) begin
        pd_now[k]  = b.cur_ctl5[8*k +: 8];
        pd_goal[k] = b.tgt_postdiv[k];
      end
    end else begin
      for (int k = 0; k < PD_USED; k++) begin
        if (pick < 0 && pd_now[k] < pd_goal[k]) pick = k;
      end
      if (pick >= 0) begin
        pd_now[pick]  = pd_now[pick] + 8'd1;
        r.write_valid = 1'b1;
        r.write_reg   = REG_CTL5;
      end else if (fb_now != fb_goal) begin
        if (fb_now < fb_goal) fb_now = fb_now + 16'd1;
        else fb_now = fb_now - 16'd1;
        r.write_valid = 1'b1;
        r.write_reg   = REG_CTL1;
        r.write_data  = {fb_now, ctl1_lo};
      end else begin
        for (int k = 0; k < PD_USED; k++) begin
          if (pick < 0 && pd_now[k] > pd_goal[k]) pick = k;
        end
        if (pick >= 0) begin
          pd_now[pick]  = pd_now[pick] - 8'd1;
          r.write_valid = 1'b1;
          r.write_reg   = REG_CTL5;
        end
      end
      if (r.write_valid && r.write_reg == REG_CTL5) begin
        for (int k = 0; k < PD_SLOTS; k++) r.write_data[8*k +: 8] = pd_now[k];
      end
    end
    settled = (fb_now == fb_goal);
    for (int k = 0; k < PD_USED; k++) begin
      if (pd_now[k] != pd_goal[k]) settled = 1'b0;
    end
    r.done_res = settled;
    return r;
  endfunction

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_now  = '0;
      fb_goal = '0;
      ctl1_lo = '0;
      for (int k = 0; k < PD_SLOTS; k++) begin
        pd_now[k]  = '0;
        pd_goal[k] = '0;
      end
      write_q.delete();
      pending_o = 0;
    end else begin
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        seen_beat.cmd            = req_i.cmd;
        seen_beat.cur_ctl1       = req_i.cur_ctl1;
        seen_beat.cur_ctl5       = req_i.cur_ctl5;
        seen_beat.tgt_fbdiv      = req_i.tgt_fbdiv;
        seen_beat.tgt_postdiv[0] = req_i.tgt_postdiv0;
        seen_beat.tgt_postdiv[1] = req_i.tgt_postdiv1;
        seen_beat.tgt_postdiv[2] = req_i.tgt_postdiv2;
        seen_beat.tgt_postdiv[3] = req_i.tgt_postdiv3;
        write_q = {write_q, ramp_step(seen_beat)};
      end
      if (res_i.valid === 1'b1 && res_i.ready === 1'b1) begin
        got.write_valid = res_i.write_valid;
        got.write_reg   = res_i.write_reg;
        got.write_data  = res_i.write_data;
        got.done_res    = res_i.done_res;
        if (write_q.size() == 0) begin
          errors_o++;
          if (errors_o <= MAX_REPORTS)
            $display("[%0t] unexpected result beat: wv=%b reg=%b data=%h done=%b",
                     $realtime, got.write_valid, got.write_reg, got.write_data,
                     got.done_res);
        end else begin
          want = write_q.pop_front();
          checked_o++;
          if (got !== want) begin
            errors_o++;
            if (errors_o <= MAX_REPORTS) begin
              $display("[%0t] result %0d mismatch: exp wv=%b reg=%b data=%h done=%b",
                       $realtime, checked_o,
                       want.write_valid, want.write_reg, want.write_data, want.done_res);
              $display("    got wv=%b reg=%b data=%h done=%b",
                       got.write_valid, got.write_reg, got.write_data, got.done_res);
            end
          end
        end
      end
      pending_o = write_q.size();
    end
  end

endmodule

// ===== tb/sv/pll_divider_ramp_sequencer_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pll_divider_ramp_sequencer_top_test
// Stimulus and verdict for the divider ramp sequencer. A directed part walks
// the field extremes, the rise / feedback / fall priority order, reloads in
// the middle of a ramp and ticks before any load. A random part then sends
// mostly complete ramps (a load followed by enough ticks to settle), some cut
// short by a reload, and some noise. Both channels idle at random; the
// checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module pll_divider_ramp_sequencer_top_test;
  import pdrs_pkg::*;

  localparam int unsigned NUM_POSTDIV = 4;
  localparam int          RANDOM_ITEMS = 2000;
  localparam int          CYCLE_LIMIT = 1000000;

  logic clk = 1'b0;
  logic rst_n;
  bit   calm;
  int   cycle_count;
  int   loads_sent;
  int   ticks_sent;
  int   errors;
  int   pending;
  int   checked;
  int   fails;

  pdrs_req_if req_bus ();
  pdrs_res_if res_bus ();

  pll_divider_ramp_sequencer_top #(
    .NUM_POSTDIV(NUM_POSTDIV)
  ) i_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_bus),
    .res_o (res_bus)
  );

  pdrs_ramp_checker #(
    .NUM_POSTDIV(NUM_POSTDIV)
  ) i_checker (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .req_i    (req_bus),
    .res_i    (res_bus),
    .errors_o (errors),
    .pending_o(pending),
    .checked_o(checked)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still awaited", cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned nudge(input int unsigned cur, input int unsigned maxv,
                                        input int spread);
    int v;
    v = int'(cur) + $urandom_range(0, 2 * spread) - spread;
    if (v < 0) v = 0;
    if (v > int'(maxv)) v = int'(maxv);
    return v;
  endfunction

  function automatic pdrs_req_t rand_beat(input logic cmd);
    pdrs_req_t b;
    b.cmd         = cmd;
    b.cur_ctl1    = $urandom;
    b.cur_ctl5    = $urandom;
    b.tgt_fbdiv   = 16'($urandom);
    b.tgt_postdiv = $urandom;
    return b;
  endfunction

  task automatic send_beat(input pdrs_req_t b);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid        <= 1'b1;
    req_bus.cmd          <= b.cmd;
    req_bus.cur_ctl1     <= b.cur_ctl1;
    req_bus.cur_ctl5     <= b.cur_ctl5;
    req_bus.tgt_fbdiv    <= b.tgt_fbdiv;
    req_bus.tgt_postdiv0 <= b.tgt_postdiv[0];
    req_bus.tgt_postdiv1 <= b.tgt_postdiv[1];
    req_bus.tgt_postdiv2 <= b.tgt_postdiv[2];
    req_bus.tgt_postdiv3 <= b.tgt_postdiv[3];
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    if (b.cmd == CMD_LOAD) loads_sent++;
    else ticks_sent++;
  endtask

  task automatic load_words(input logic [31:0] c1, input logic [31:0] c5,
                            input logic [15:0] fb, input logic [31:0] pd);
    pdrs_req_t b;
    b.cmd         = CMD_LOAD;
    b.cur_ctl1    = c1;
    b.cur_ctl5    = c5;
    b.tgt_fbdiv   = fb;
    b.tgt_postdiv = pd;
    send_beat(b);
  endtask

  task automatic ticks(input int n);
    repeat (n) send_beat(rand_beat(CMD_TICK));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  // Load near or far targets, then tick toward them; a cut ramp may stop early.
  task automatic run_ramp(input bit cut);
    pdrs_req_t b;
    int        span;
    int        spread;
    b      = rand_beat(CMD_LOAD);
    spread = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 30) : $urandom_range(0, 3);
    b.tgt_fbdiv = 16'(nudge(b.cur_ctl1[31:16], 16'hFFFF, spread));
    span = (b.tgt_fbdiv > b.cur_ctl1[31:16]) ? int'(b.tgt_fbdiv - b.cur_ctl1[31:16])
                                             : int'(b.cur_ctl1[31:16] - b.tgt_fbdiv);
    for (int k = 0; k < PD_SLOTS; k++) begin
      spread = $urandom_range(0, 3);
      b.tgt_postdiv[k] = 8'(nudge(b.cur_ctl5[8*k +: 8], 8'hFF, spread));
      span += (b.tgt_postdiv[k] > b.cur_ctl5[8*k +: 8])
              ? int'(b.tgt_postdiv[k] - b.cur_ctl5[8*k +: 8])
              : int'(b.cur_ctl5[8*k +: 8] - b.tgt_postdiv[k]);
    end
    send_beat(b);
    if (cut) ticks($urandom_range(0, span));
    else ticks(span + $urandom_range(0, 2));
  endtask

  initial begin
    int  r;
    bit  paused;
    req_bus.valid        = 1'b0;
    req_bus.cmd          = CMD_LOAD;
    req_bus.cur_ctl1     = '0;
    req_bus.cur_ctl5     = '0;
    req_bus.tgt_fbdiv    = '0;
    req_bus.tgt_postdiv0 = '0;
    req_bus.tgt_postdiv1 = '0;
    req_bus.tgt_postdiv2 = '0;
    req_bus.tgt_postdiv3 = '0;
    cycle_count          = 0;
    loads_sent           = 0;
    ticks_sent           = 0;
    paused               = 1'b0;
    calm                 = 1'b0;
    rst_n                = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    ticks(1);
    load_words(32'h0000_0000, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    ticks(1);
    load_words(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    ticks(1);
    load_words(32'h0000_5A5A, 32'h0000_0000, 16'h0001, 32'h0101_0101);
    ticks(6);
    load_words(32'hFFFF_A5A5, 32'hFFFF_FF01, 16'hFFFE, 32'hFEFF_FF02);
    ticks(4);
    load_words(32'hFFFE_FFFF, 32'h02FE_0001, 16'hFFFF, 32'h00FF_0100);
    ticks(2);
    load_words(32'h0001_1234, 32'h0000_0000, 16'h0000, 32'h0000_0000);
    ticks(3);
    wait_drained();

    while (loads_sent + ticks_sent < RANDOM_ITEMS) begin
      r    = loads_sent + ticks_sent;
      calm = (r > 600 && r < 900);
      r    = $urandom_range(0, 99);
      if (r < 70) run_ramp(1'b0);
      else if (r < 85) run_ramp(1'b1);
      else repeat ($urandom_range(1, 4)) send_beat(rand_beat(1'($urandom_range(0, 1))));
      if (!paused && loads_sent + ticks_sent > 1200) begin
        wait_drained();
        paused = 1'b1;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    fails = errors + pending;
    $display("Sent %0d load beats and %0d tick beats; %0d result beats checked, %0d errors",
             loads_sent, ticks_sent, checked, errors);
    $display("Covered rise, feedback and fall steps, reloads mid-ramp and random stalls");
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left    = 0;
    res_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        res_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        res_bus.ready <= 1'b1;
        if (!calm && $urandom_range(0, 99) < 20) stall_left = pick_gap();
      end
    end
  end

endmodule

// ===== sim.f =====
rtl/pdrs_pkg.sv
rtl/pdrs_if.sv
rtl/pdrs_step.sv
rtl/pll_divider_ramp_sequencer_top.sv
tb/sv/pdrs_ramp_checker.sv
tb/sv/pll_divider_ramp_sequencer_top_test.sv
